/* design/c2p_pkg.sv */
// Shared constants, types and the arctangent table for the Cartesian-to-polar core.
package c2p_pkg;

  localparam int DW      = 32;  // input/output word width
  localparam int PW      = 64;  // product and radicand width
  localparam int SQRT_N  = 32;  // root bits, one per stage
  localparam int DIV_N   = 32;  // quotient bits, one per stage
  localparam int CORDIC_N = 30; // rotation steps
  localparam int XW      = 58;  // CORDIC x/y width
  localparam int ZW      = 34;  // CORDIC angle width (Q2.30 plus headroom)
  localparam int BW      = 19;  // bearing width, Q3.16
  localparam int TW      = 16;  // threshold register width

  localparam logic [TW-1:0] THR_RESET = 16'd7;
  localparam logic [ZW-1:0] PI30      = 34'd3373259426;

  typedef struct packed {
    logic [PW-1:0] mag;
    logic          neg;
  } dot_t;

  // atan(2^-i) in Q2.30
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'h03243F6A8;
      5'd1:  v = 34'h01DAC6705;
      5'd2:  v = 34'h00FADBAFC;
      5'd3:  v = 34'h007F56EA6;
      5'd4:  v = 34'h003FEAB76;
      5'd5:  v = 34'h001FFD55B;
      5'd6:  v = 34'h000FFFAAA;
      5'd7:  v = 34'h0007FFF55;
      5'd8:  v = 34'h0003FFFEA;
      5'd9:  v = 34'h0001FFFFD;
      5'd10: v = 34'h0000FFFFF;
      5'd11: v = 34'h00007FFFF;
      5'd12: v = 34'h00003FFFF;
      5'd13: v = 34'h00001FFFF;
      5'd14: v = 34'h00000FFFF;
      5'd15: v = 34'h000007FFF;
      5'd16: v = 34'h000003FFF;
      5'd17: v = 34'h000001FFF;
      5'd18: v = 34'h000000FFF;
      5'd19: v = 34'h0000007FF;
      5'd20: v = 34'h0000003FF;
      5'd21: v = 34'h0000001FF;
      5'd22: v = 34'h0000000FF;
      5'd23: v = 34'h00000007F;
      5'd24: v = 34'h00000003F;
      5'd25: v = 34'h00000001F;
      5'd26: v = 34'h00000000F;
      5'd27: v = 34'h000000008;
      5'd28: v = 34'h000000004;
      5'd29: v = 34'h000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/c2p_mult.sv */
// Squares and cross products, then radicand sum and signed dot product (two stages).
module c2p_mult (
  input  logic                 clk,
  input  logic                 en,
  input  logic [c2p_pkg::DW-1:0] ax,
  input  logic [c2p_pkg::DW-1:0] ay,
  input  logic [c2p_pkg::DW-1:0] avx,
  input  logic [c2p_pkg::DW-1:0] avy,
  input  logic                 n1_sign,
  input  logic                 n2_sign,
  output logic [c2p_pkg::PW-1:0] rad,
  output c2p_pkg::dot_t        dot
);
  import c2p_pkg::*;

  logic [PW-1:0] ax2_r, ay2_r, p1_r, p2_r;
  logic          s1_r, s2_r;
  logic [PW-1:0] rad_r;
  dot_t          dot_r, dot_nxt;
  logic          n1, n2;

  always_comb begin
    n1 = s1_r && (p1_r != '0);
    n2 = s2_r && (p2_r != '0);
    if (n1 == n2) begin
      dot_nxt.mag = p1_r + p2_r;
      dot_nxt.neg = n1;
    end else if (p1_r >= p2_r) begin
      dot_nxt.mag = p1_r - p2_r;
      dot_nxt.neg = n1;
    end else begin
      dot_nxt.mag = p2_r - p1_r;
      dot_nxt.neg = n2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= PW'(ax) * PW'(ax);
      ay2_r <= PW'(ay) * PW'(ay);
      p1_r  <= PW'(ax) * PW'(avx);
      p2_r  <= PW'(ay) * PW'(avy);
      s1_r  <= n1_sign;
      s2_r  <= n2_sign;
      rad_r <= ax2_r + ay2_r;
      dot_r <= dot_nxt;
    end
  end

  assign rad = rad_r;
  assign dot = dot_r;
endmodule

/* design/c2p_sqrt.sv */
// Pipelined integer square root, one root bit per stage; dot product rides along.
module c2p_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [c2p_pkg::PW-1:0] rad,
  input  c2p_pkg::dot_t          dot_in,
  output logic [c2p_pkg::DW-1:0] root,
  output c2p_pkg::dot_t          dot_out
);
  import c2p_pkg::*;

  logic [PW-1:0] rad_r  [SQRT_N];
  logic [DW+1:0] rem_r  [SQRT_N];
  logic [DW-1:0] root_r [SQRT_N];
  dot_t          dot_r  [SQRT_N];

  for (genvar s = 0; s < SQRT_N; s++) begin : g_stage
    logic [PW-1:0] rad_in;
    logic [DW+1:0] rem_in;
    logic [DW-1:0] root_in;
    dot_t          dot_i;
    logic [DW+3:0] trial, tval;

    if (s == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign dot_i   = dot_in;
    end else begin : g_rest
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign dot_i   = dot_r[s-1];
    end

    assign trial = {rem_in, rad_in[PW-1 -: 2]};
    assign tval  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s] <= {rad_in[PW-3:0], 2'b00};
        dot_r[s] <= dot_i;
        if (trial >= tval) begin
          rem_r[s]  <= (DW+2)'(trial - tval);
          root_r[s] <= {root_in[DW-2:0], 1'b1};
        end else begin
          rem_r[s]  <= (DW+2)'(trial);
          root_r[s] <= {root_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign root    = root_r[SQRT_N-1];
  assign dot_out = dot_r[SQRT_N-1];
endmodule

/* design/c2p_div.sv */
// Pipelined restoring divide of the dot product by range, then threshold and saturation.
module c2p_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [c2p_pkg::TW-1:0] thr,
  input  logic [c2p_pkg::DW-1:0] rho,
  input  c2p_pkg::dot_t          dot,
  output logic [c2p_pkg::DW-1:0] range_out,
  output logic [c2p_pkg::DW-1:0] rate_out
);
  import c2p_pkg::*;

  logic [DW-1:0] rho_r  [DIV_N];
  logic [DW-1:0] rem_r  [DIV_N];
  logic [DW-1:0] lo_r   [DIV_N];
  logic [DW-1:0] q_r    [DIV_N];
  logic          neg_r  [DIV_N];
  logic          zero_r [DIV_N];
  logic          ovf_r  [DIV_N];

  logic [DW-1:0] range_r, rate_r, rate_nxt, qs;
  logic          zero_in, ovf_in;

  assign zero_in = rho <= DW'(thr);
  // quotient needs more than 32 bits
  assign ovf_in  = dot.mag[PW-1:DW] >= rho;

  for (genvar s = 0; s < DIV_N; s++) begin : g_stage
    logic [DW-1:0] rho_i, rem_i, lo_i, q_i;
    logic          neg_i, zero_i, ovf_i;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign rho_i  = rho;
      assign rem_i  = dot.mag[PW-1:DW];
      assign lo_i   = dot.mag[DW-1:0];
      assign q_i    = '0;
      assign neg_i  = dot.neg;
      assign zero_i = zero_in;
      assign ovf_i  = ovf_in;
    end else begin : g_rest
      assign rho_i  = rho_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign lo_i   = lo_r[s-1];
      assign q_i    = q_r[s-1];
      assign neg_i  = neg_r[s-1];
      assign zero_i = zero_r[s-1];
      assign ovf_i  = ovf_r[s-1];
    end

    assign trial = {rem_i, lo_i[DW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rho_r[s]  <= rho_i;
        lo_r[s]   <= {lo_i[DW-2:0], 1'b0};
        neg_r[s]  <= neg_i;
        zero_r[s] <= zero_i;
        ovf_r[s]  <= ovf_i;
        if (trial >= {1'b0, rho_i}) begin
          rem_r[s] <= DW'(trial - {1'b0, rho_i});
          q_r[s]   <= {q_i[DW-2:0], 1'b1};
        end else begin
          rem_r[s] <= DW'(trial);
          q_r[s]   <= {q_i[DW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qs = q_r[DIV_N-1];
    if (zero_r[DIV_N-1]) begin
      rate_nxt = '0;
    end else if (neg_r[DIV_N-1]) begin
      if (ovf_r[DIV_N-1] || qs > 32'h8000_0000) qs = 32'h8000_0000;
      rate_nxt = DW'(~qs + 1'b1);
    end else begin
      if (ovf_r[DIV_N-1] || qs[DW-1]) qs = 32'h7FFF_FFFF;
      rate_nxt = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_r <= rho_r[DIV_N-1];
      rate_r  <= rate_nxt;
    end
  end

  assign range_out = range_r;
  assign rate_out  = rate_r;
endmodule

/* design/c2p_cordic.sv */
// Vectoring CORDIC bearing, one rotation per stage, with quadrant fix and rounding.
module c2p_cordic (
  input  logic                   clk,
  input  logic                   en,
  input  logic [c2p_pkg::DW-1:0] ax,
  input  logic [c2p_pkg::DW-1:0] ay,
  input  logic                   npx,
  input  logic                   npy,
  output logic [c2p_pkg::BW-1:0] bearing
);
  import c2p_pkg::*;

  logic signed [XW-1:0] x_r [CORDIC_N];
  logic signed [XW-1:0] y_r [CORDIC_N];
  logic signed [ZW-1:0] z_r [CORDIC_N];
  logic                 npx_r [CORDIC_N];
  logic                 npy_r [CORDIC_N];
  logic                 org_r [CORDIC_N];

  logic signed [ZW+1:0] theta, rnd;
  logic [BW-1:0]        bearing_r;

  for (genvar s = 0; s < CORDIC_N; s++) begin : g_stage
    logic signed [XW-1:0] x_i, y_i, xs, ys;
    logic signed [ZW-1:0] z_i, at;
    logic                 npx_i, npy_i, org_i;

    if (s == 0) begin : g_first
      assign x_i   = {2'b00, ax, 24'd0};
      assign y_i   = {2'b00, ay, 24'd0};
      assign z_i   = '0;
      assign npx_i = npx;
      assign npy_i = npy;
      assign org_i = (ax == '0) && (ay == '0);
    end else begin : g_rest
      assign x_i   = x_r[s-1];
      assign y_i   = y_r[s-1];
      assign z_i   = z_r[s-1];
      assign npx_i = npx_r[s-1];
      assign npy_i = npy_r[s-1];
      assign org_i = org_r[s-1];
    end

    assign xs = x_i >>> s;
    assign ys = y_i >>> s;
    assign at = atan_lut(5'(s));

    always_ff @(posedge clk) begin
      if (en) begin
        npx_r[s] <= npx_i;
        npy_r[s] <= npy_i;
        org_r[s] <= org_i;
        if (!y_i[XW-1]) begin
          x_r[s] <= x_i + ys;
          y_r[s] <= y_i - xs;
          z_r[s] <= z_i + at;
        end else begin
          x_r[s] <= x_i - ys;
          y_r[s] <= y_i + xs;
          z_r[s] <= z_i - at;
        end
      end
    end
  end

  always_comb begin
    if (org_r[CORDIC_N-1]) begin
      theta = '0;
    end else if (npx_r[CORDIC_N-1]) begin
      theta = $signed({2'b00, PI30}) - (ZW+2)'(z_r[CORDIC_N-1]);
    end else begin
      theta = (ZW+2)'(z_r[CORDIC_N-1]);
    end
    if (npy_r[CORDIC_N-1]) theta = -theta;
    rnd = theta + (ZW+2)'(8192);
  end

  always_ff @(posedge clk) begin
    if (en) bearing_r <= rnd[BW+13:14];
  end

  assign bearing = bearing_r;
endmodule

/* design/cartesian_to_polar_radar_core.sv */
// Top level of the Cartesian-to-polar radar measurement core.
// Converts one track state (px, py, vx, vy in signed Q16.16) per transfer into range
// (unsigned Q16.16), bearing (signed Q3.16 radians) and range rate (signed Q16.16,
// saturated, zero when range <= range threshold). Fully pipelined: one item per clock
// while the output is not stalled; the path from input transfer to output valid runs
// through the 32-stage square root followed by the 32-stage divider; the CORDIC runs
// alongside. The whole pipe stalls only while a result sits unaccepted at the output.
module cartesian_to_polar_radar_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [127:0] in_tdata,  // position_x, position_y, velocity_x, velocity_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // range_out[31:0], bearing_out[50:32], range_rate_out[82:51]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // range_threshold
);
  import c2p_pkg::*;

  localparam int LAT = 68;
  localparam int BDLY = 36;

  logic [TW-1:0] thr_r;
  logic [LAT-1:0] vld_r;
  logic en;

  logic [DW-1:0] px_r, py_r, vx_r, vy_r;
  logic [DW-1:0] ax, ay, avx, avy;
  logic [PW-1:0] rad;
  dot_t          dot_m, dot_s;
  logic [DW-1:0] rho, range_o, rate_o;
  logic [BW-1:0] bear_c;
  logic [BW-1:0] bdly_r [BDLY];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_tdata[31:0];
      py_r <= in_tdata[63:32];
      vx_r <= in_tdata[95:64];
      vy_r <= in_tdata[127:96];
    end
  end

  assign ax  = px_r[DW-1] ? DW'(~px_r + 1'b1) : px_r;
  assign ay  = py_r[DW-1] ? DW'(~py_r + 1'b1) : py_r;
  assign avx = vx_r[DW-1] ? DW'(~vx_r + 1'b1) : vx_r;
  assign avy = vy_r[DW-1] ? DW'(~vy_r + 1'b1) : vy_r;

  c2p_mult u_mult (
    .clk, .en, .ax, .ay, .avx, .avy,
    .n1_sign(px_r[DW-1] ^ vx_r[DW-1]),
    .n2_sign(py_r[DW-1] ^ vy_r[DW-1]),
    .rad, .dot(dot_m)
  );

  c2p_sqrt u_sqrt (.clk, .en, .rad, .dot_in(dot_m), .root(rho), .dot_out(dot_s));

  c2p_div u_div (
    .clk, .en, .thr(thr_r), .rho, .dot(dot_s), .range_out(range_o), .rate_out(rate_o)
  );

  c2p_cordic u_cordic (
    .clk, .en, .ax, .ay, .npx(px_r[DW-1]), .npy(py_r[DW-1]), .bearing(bear_c)
  );

  // align bearing with the longer sqrt/divide path
  always_ff @(posedge clk) begin
    if (en) begin
      bdly_r[0] <= bear_c;
      for (int i = 1; i < BDLY; i++) bdly_r[i] <= bdly_r[i-1];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {5'd0, rate_o, bdly_r[BDLY-1], range_o};

  a_small_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] <= {16'd0, thr_r}) |-> out_tdata[82:51] == '0)
    else $error("range rate not zero at small range");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] == '0) |-> out_tdata[50:32] == '0)
    else $error("bearing not zero at origin");

  a_bearing_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[50:32]) <= 19'sd205887) &&
                   ($signed(out_tdata[50:32]) >= -19'sd205887))
    else $error("bearing outside minus pi to pi");
endmodule
